// ===== design/bpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the blink and portrait timer.
// Used by every module of the block but the checker; depends on nothing else.
package bpt_pkg;

    // Item and register field widths.
    localparam int TIME_W   = 32;
    localparam int STATE_W  = 3;
    localparam int DUR_W    = 16;
    localparam int OP_W     = 2;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 72;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Default seed, and timing constants in milliseconds.
    localparam logic [TIME_W-1:0] SEED_DEFAULT    = 32'h4348_444B;
    localparam logic [TIME_W-1:0] BLINK_BASE_MS   = 32'd4000;
    localparam logic [TIME_W-1:0] BLINK_SPAN      = 32'd3001;
    localparam logic [TIME_W-1:0] BLINK_LEN_MS    = 32'd120;
    localparam logic [DUR_W-1:0]  PORTRAIT_MAX_MS = 16'd10000;

    // Xorshift32 shift amounts.
    localparam int XS_A = 13;
    localparam int XS_B = 17;
    localparam int XS_C = 5;

    // Remainder by the blink span: reciprocal multiply, then one correction.
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 29;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(BLINK_SPAN);
    localparam logic [RECIP_W-1:0] SPAN_RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W   = TIME_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - RECIP_SHIFT;
    localparam int REM_W    = 13;
    localparam int OFFSET_W = 12;

    // Depth of the look-ahead offset queue.
    localparam int FIFO_DEPTH = 4;

    // Device states that suppress blinking.
    localparam logic [STATE_W-1:0] ST_LISTENING = 3'd1;
    localparam logic [STATE_W-1:0] ST_ERROR     = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DISPLAY_MODE = 2'd0;
    localparam logic [1:0] REG_ARTWORK      = 2'd1;
    localparam logic [1:0] REG_PORTRAIT     = 2'd2;
    localparam logic [1:0] REG_SEED         = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 2'd0,
        OP_SET_STATE = 2'd1,
        OP_PORTRAIT  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_HYBRID = 2'd0,
        MODE_ART    = 2'd1,
        MODE_NATIVE = 2'd2
    } mode_t;

    // Configuration seen by the datapath, plus one-cycle event pulses.
    typedef struct packed {
        logic [1:0]        display_mode;
        logic              artwork_allowed;
        logic              portrait_available;
        logic [TIME_W-1:0] seed_eff;
        logic              clear_portrait;
        logic              reseed;
    } cfg_t;

    // Character art without artwork permission, and code 3, act as native face.
    function automatic mode_t eff_mode(input logic [1:0] mode, input logic art);
        mode_t m;
        if (mode == MODE_HYBRID)
            m = MODE_HYBRID;
        else if (mode == MODE_ART && art)
            m = MODE_ART;
        else
            m = MODE_NATIVE;
        return m;
    endfunction

    function automatic logic [TIME_W-1:0] xorshift32(input logic [TIME_W-1:0] w);
        logic [TIME_W-1:0] v;
        v = w;
        v = v ^ (v << XS_A);
        v = v ^ (v >> XS_B);
        v = v ^ (v << XS_C);
        return v;
    endfunction

endpackage

// ===== design/bpt_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on bpt_pkg for register indexes, the mode function and cfg_t.
module bpt_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpt_pkg::ADDR_W-1:0] paddr,
    input  logic [bpt_pkg::DATA_W-1:0] pwdata,
    output logic [bpt_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bpt_pkg::cfg_t              cfg
);

    logic [1:0]                 mode_reg, mode_next;
    logic                       art_reg, art_next;
    logic                       avail_reg, avail_next;
    logic [bpt_pkg::TIME_W-1:0] seed_reg, seed_next;
    logic                       clear_reg, clear_next;
    logic                       reseed_reg, reseed_next;
    logic                       wr_en;
    logic [1:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes and the side effects they trigger.
    always_comb
    begin
        mode_next   = mode_reg;
        art_next    = art_reg;
        avail_next  = avail_reg;
        seed_next   = seed_reg;
        clear_next  = 1'b0;
        reseed_next = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                bpt_pkg::REG_DISPLAY_MODE:
                begin
                    mode_next  = pwdata[1:0];
                    clear_next = (bpt_pkg::eff_mode(pwdata[1:0], art_reg)
                                  == bpt_pkg::MODE_NATIVE);
                end
                bpt_pkg::REG_ARTWORK:
                begin
                    art_next   = pwdata[0];
                    clear_next = ~pwdata[0];
                end
                bpt_pkg::REG_PORTRAIT:
                begin
                    avail_next = pwdata[0];
                    clear_next = ~pwdata[0];
                end
                bpt_pkg::REG_SEED:
                begin
                    seed_next   = pwdata;
                    reseed_next = 1'b1;
                end
                default:
                begin
                    clear_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            art_reg    <= 1'b0;
            avail_reg  <= 1'b0;
            seed_reg   <= '0;
            clear_reg  <= 1'b0;
            reseed_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            art_reg    <= art_next;
            avail_reg  <= avail_next;
            seed_reg   <= seed_next;
            clear_reg  <= clear_next;
            reseed_reg <= reseed_next;
        end
    end

    // Read data follows the address directly.
    always_comb
    begin
        unique case (reg_idx)
            bpt_pkg::REG_DISPLAY_MODE: prdata = {30'd0, mode_reg};
            bpt_pkg::REG_ARTWORK:      prdata = {31'd0, art_reg};
            bpt_pkg::REG_PORTRAIT:     prdata = {31'd0, avail_reg};
            bpt_pkg::REG_SEED:         prdata = seed_reg;
            default:                   prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.display_mode       = mode_reg;
        cfg.artwork_allowed    = art_reg;
        cfg.portrait_available = avail_reg;
        cfg.seed_eff           = (seed_reg == '0) ? bpt_pkg::SEED_DEFAULT : seed_reg;
        cfg.clear_portrait     = clear_reg;
        cfg.reseed             = reseed_reg;
    end

endmodule

// ===== design/bpt_offset_gen.sv =====
`timescale 1ns / 1ps
// Look-ahead generator of blink offsets: xorshift32, a pipelined remainder by
// the blink span, and a small queue. Depends on bpt_pkg for constants.
module bpt_offset_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         reseed,
    input  logic [bpt_pkg::TIME_W-1:0]   seed_eff,
    input  logic                         pop,
    output logic                         head_valid,
    output logic [bpt_pkg::OFFSET_W-1:0] head_offset
);

    localparam int PTR_W = $clog2(bpt_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(bpt_pkg::FIFO_DEPTH + 1);

    logic [bpt_pkg::TIME_W-1:0]   gen_reg, gen_next;
    logic                         v1_reg, v1_next;
    logic [bpt_pkg::TIME_W-1:0]   x1_reg;
    logic [bpt_pkg::PROD_W-1:0]   prod1_reg;
    logic                         v2_reg, v2_next;
    logic [bpt_pkg::REM_W-1:0]    rem2_reg;
    logic [bpt_pkg::OFFSET_W-1:0] fifo_mem_reg [bpt_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    logic [CNT_W-1:0]             total;
    logic                         issue;
    logic [bpt_pkg::TIME_W-1:0]   x_issue;
    logic [bpt_pkg::PROD_W-1:0]   prod_next;
    logic [bpt_pkg::QUOT_W-1:0]   quot;
    logic [bpt_pkg::TIME_W-1:0]   quot_span;
    logic [bpt_pkg::TIME_W-1:0]   rem_wide;
    logic [bpt_pkg::REM_W-1:0]    rem_fix;

    assign head_valid  = (count_reg != '0);
    assign head_offset = fifo_mem_reg[rd_ptr_reg];

    // Issue a new word while queue plus pipeline stay within the queue depth.
    always_comb
    begin
        total = count_reg + CNT_W'(v1_reg) + CNT_W'(v2_reg);
        issue = ~reseed & ((total < CNT_W'(bpt_pkg::FIFO_DEPTH)) | pop);
        x_issue   = bpt_pkg::xorshift32(gen_reg);
        prod_next = bpt_pkg::PROD_W'(x_issue) * bpt_pkg::PROD_W'(bpt_pkg::SPAN_RECIP);
    end

    // Stage two: remainder estimate, known to lie below twice the span.
    always_comb
    begin
        quot      = prod1_reg[bpt_pkg::PROD_W-1:bpt_pkg::RECIP_SHIFT];
        quot_span = bpt_pkg::TIME_W'(quot) * bpt_pkg::BLINK_SPAN;
        rem_wide  = x1_reg - quot_span;
    end

    // Stage three: final correction before the word enters the queue.
    always_comb
    begin
        if (rem2_reg >= bpt_pkg::REM_W'(bpt_pkg::BLINK_SPAN))
            rem_fix = rem2_reg - bpt_pkg::REM_W'(bpt_pkg::BLINK_SPAN);
        else
            rem_fix = rem2_reg;
    end

    // Control next-state: a seed reload flushes the pipeline and the queue.
    always_comb
    begin
        if (reseed)
        begin
            gen_next    = seed_eff;
            v1_next     = 1'b0;
            v2_next     = 1'b0;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            gen_next    = issue ? x_issue : gen_reg;
            v1_next     = issue;
            v2_next     = v1_reg;
            wr_ptr_next = wr_ptr_reg + PTR_W'(v2_reg);
            rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
            count_next  = count_reg + CNT_W'(v2_reg) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg    <= bpt_pkg::SEED_DEFAULT;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            gen_reg    <= gen_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Datapath registers of the remainder pipeline and the queue entries.
    always_ff @(posedge clk)
    begin
        x1_reg    <= x_issue;
        prod1_reg <= prod_next;
        rem2_reg  <= rem_wide[bpt_pkg::REM_W-1:0];
        if (v2_reg && !reseed)
            fifo_mem_reg[wr_ptr_reg] <= rem_fix[bpt_pkg::OFFSET_W-1:0];
    end

endmodule

// ===== design/bpt_core.sv =====
`timescale 1ns / 1ps
// Item datapath: input register, blink and portrait state update, result register.
// Depends on bpt_pkg and takes blink offsets from bpt_offset_gen.
module bpt_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bpt_pkg::cfg_t                cfg,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bpt_pkg::IN_W-1:0]     s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bpt_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         head_valid,
    input  logic [bpt_pkg::OFFSET_W-1:0] head_offset,
    output logic                         pop
);

    localparam int TW = bpt_pkg::TIME_W;

    // Input register.
    logic                     in_valid_reg, in_valid_next;
    logic [bpt_pkg::IN_W-1:0] in_data_reg;

    // Block state.
    logic                     shut_reg, shut_next;
    logic                     pflag_reg, pflag_next;
    logic [TW-1:0]            pend_reg, pend_next;
    logic [TW-1:0]            bend_reg, bend_next;
    logic [TW-1:0]            due_reg, due_next;
    logic [bpt_pkg::STATE_W-1:0] cur_reg, cur_next;
    logic [TW-1:0]            changed_reg, changed_next;
    logic                     due_pending_reg, due_pending_next;

    // Result register.
    logic                      out_valid_reg, out_valid_next;
    logic [bpt_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // Decoded item and per-item working signals.
    bpt_pkg::op_t                op;
    logic [TW-1:0]               now;
    logic [bpt_pkg::STATE_W-1:0] st;
    logic [bpt_pkg::DUR_W-1:0]   dur;
    logic [bpt_pkg::DUR_W-1:0]   dur_clamped;
    bpt_pkg::mode_t              eff;
    logic                        fire;
    logic                        plan;
    logic [TW-1:0]               due_plan;
    logic [TW-1:0]               since_end;
    logic [TW-1:0]               remain;
    logic                        render;
    logic                        item_shut;
    logic                        item_pflag;
    logic [TW-1:0]               item_pend;
    logic [TW-1:0]               item_bend;
    logic [TW-1:0]               item_due;
    logic [bpt_pkg::STATE_W-1:0] item_cur;
    logic [TW-1:0]               item_changed;

    assign op  = bpt_pkg::op_t'(in_data_reg[1:0]);
    assign now = in_data_reg[33:2];
    assign st  = in_data_reg[36:34];
    assign dur = in_data_reg[52:37];
    assign eff = bpt_pkg::eff_mode(cfg.display_mode, cfg.artwork_allowed);

    // An item goes through when the result slot frees up, an offset is on hand and no first schedule is pending.
    assign fire     = in_valid_reg & (~out_valid_reg | m_tready) & head_valid
                      & ~due_pending_reg;
    assign s_tready = ~in_valid_reg | fire;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pop      = (fire & plan) | (due_pending_reg & head_valid);

    // State update for the item held in the input register.
    always_comb
    begin
        item_shut    = shut_reg;
        item_pflag   = pflag_reg;
        item_pend    = pend_reg;
        item_bend    = bend_reg;
        item_due     = due_reg;
        item_cur     = cur_reg;
        item_changed = changed_reg;
        plan         = 1'b0;
        due_plan     = now + bpt_pkg::BLINK_BASE_MS + TW'(head_offset);
        since_end    = now - pend_reg;
        dur_clamped  = (dur > bpt_pkg::PORTRAIT_MAX_MS) ? bpt_pkg::PORTRAIT_MAX_MS : dur;
        unique case (op)
            bpt_pkg::OP_TICK:
            begin
                // Hybrid mode drops the request once its end time has passed.
                if (pflag_reg && eff == bpt_pkg::MODE_HYBRID && !since_end[TW-1])
                    item_pflag = 1'b0;
                if (cur_reg == bpt_pkg::ST_ERROR || cur_reg == bpt_pkg::ST_LISTENING)
                begin
                    item_shut = 1'b0;
                    plan      = (now >= due_reg);
                end
                else if (!shut_reg && now >= due_reg)
                begin
                    item_shut = 1'b1;
                    item_bend = now + bpt_pkg::BLINK_LEN_MS;
                end
                else if (shut_reg && now >= bend_reg)
                begin
                    item_shut = 1'b0;
                    plan      = 1'b1;
                end
                if (plan)
                    item_due = due_plan;
            end
            bpt_pkg::OP_SET_STATE:
            begin
                if (st != cur_reg)
                begin
                    item_cur     = st;
                    item_changed = now;
                end
            end
            bpt_pkg::OP_PORTRAIT:
            begin
                if (cfg.artwork_allowed && eff != bpt_pkg::MODE_NATIVE)
                begin
                    item_pflag = 1'b1;
                    item_pend  = now + TW'(dur_clamped);
                end
            end
            default:
            begin
                plan = 1'b0;
            end
        endcase

        // Portrait rendering decision after the operation.
        remain = item_pend - now;
        if (!cfg.artwork_allowed || !cfg.portrait_available
            || eff == bpt_pkg::MODE_NATIVE)
            render = 1'b0;
        else if (eff == bpt_pkg::MODE_ART)
            render = 1'b1;
        else
            render = item_pflag & (remain != '0) & ~remain[TW-1];

        out_data_next = {5'd0, item_changed, item_due, item_pflag, render, item_shut};
    end

    // Next state: configuration events, the first schedule after reset or a reseed, items.
    always_comb
    begin
        shut_next        = shut_reg;
        pflag_next       = pflag_reg;
        pend_next        = pend_reg;
        bend_next        = bend_reg;
        due_next         = due_reg;
        cur_next         = cur_reg;
        changed_next     = changed_reg;
        due_pending_next = due_pending_reg;
        if (cfg.reseed)
        begin
            due_pending_next = 1'b1;
        end
        else if (due_pending_reg && head_valid)
        begin
            due_next         = bpt_pkg::BLINK_BASE_MS + TW'(head_offset);
            due_pending_next = 1'b0;
        end
        else if (fire)
        begin
            shut_next    = item_shut;
            pflag_next   = item_pflag;
            pend_next    = item_pend;
            bend_next    = item_bend;
            due_next     = item_due;
            cur_next     = item_cur;
            changed_next = item_changed;
        end
        if (cfg.clear_portrait)
            pflag_next = 1'b0;

        in_valid_next  = (s_tvalid & s_tready) | (in_valid_reg & ~fire);
        out_valid_next = fire | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            shut_reg        <= 1'b0;
            pflag_reg       <= 1'b0;
            pend_reg        <= '0;
            bend_reg        <= '0;
            due_reg         <= '0;
            cur_reg         <= '0;
            changed_reg     <= '0;
            due_pending_reg <= 1'b1;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            shut_reg        <= shut_next;
            pflag_reg       <= pflag_next;
            pend_reg        <= pend_next;
            bend_reg        <= bend_next;
            due_reg         <= due_next;
            cur_reg         <= cur_next;
            changed_reg     <= changed_next;
            due_pending_reg <= due_pending_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (fire)
            out_data_reg <= out_data_next;
    end

endmodule

// ===== design/blink_and_portrait_timer.sv =====
`timescale 1ns / 1ps
// Top level of the blink and portrait timer.
// Instantiates bpt_cfg_regs, bpt_offset_gen and bpt_core; uses bpt_pkg.
//
// Usage:
//   Items arrive on the s_axis stream (op, now_ms, device_state, duration_ms)
//   and every accepted item yields exactly one result transaction on m_axis
//   (eyes_closed, render_portrait, portrait_pending, next_blink_time,
//   state_change_time). Registers are written over the APB-style port while
//   the stream is idle; pready is always high and reads return register values.
//   An accepted item passes the input register, then the result register. The
//   block sustains one item per cycle while results are taken and no rebuild
//   is pending; that rate is set by the single-pass update between the input
//   and result registers, fed by a queue of precomputed blink offsets that a
//   three-stage remainder pipeline keeps topped up. The queue and the first
//   blink schedule are rebuilt after reset or a seed register write; meanwhile
//   items wait in the input register. If the receiver stalls, the result holds
//   in the output register, one more item is taken into the input register,
//   and then s_axis_tready drops until the result is taken.
module blink_and_portrait_timer (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: op[1:0], now_ms[33:2], device_state[36:34],
    // duration_ms[52:37], zero fill [55:53]
    input  logic [55:0] s_axis_tdata,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: eyes_closed[0], render_portrait[1], portrait_pending[2],
    // next_blink_time[34:3], state_change_time[66:35], zero fill [71:67]
    output logic [71:0] m_axis_tdata
);

    bpt_pkg::cfg_t                cfg;
    logic                         head_valid;
    logic [bpt_pkg::OFFSET_W-1:0] head_offset;
    logic                         pop;

    bpt_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpt_offset_gen u_offset_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .reseed      (cfg.reseed),
        .seed_eff    (cfg.seed_eff),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_offset (head_offset)
    );

    bpt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .head_valid  (head_valid),
        .head_offset (head_offset),
        .pop         (pop)
    );

endmodule

// ===== design/bpt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the blink and portrait timer, bound to the top level.
// Depends only on the top level's ports.
module bpt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);

    // A stalled result stays offered with the same contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or dropped while stalled");

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
    else $error("result offered during reset");

    // A display mode write reads back in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == 2'd0)
        ##1 (psel && !pwrite && paddr[3:2] == 2'd0)
        |-> (prdata[1:0] == $past(pwdata[1:0])))
    else $error("display mode readback mismatch");

    // An artwork permission write reads back in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[3:2] == 2'd1)
        ##1 (psel && !pwrite && paddr[3:2] == 2'd1)
        |-> (prdata[0] == $past(pwdata[0])))
    else $error("artwork permission readback mismatch");

endmodule

bind blink_and_portrait_timer bpt_checker u_bpt_checker (.*);
